@@ hdl/fmtrh_pkg.sv @@
// Shared types and constants for the tile rectangle hit test unit.
// Field widths, register indexes, item kinds and the queued transaction type.
// No dependencies.
`default_nettype none

package fmtrh_pkg;

    // fixed field widths
    localparam int SLOT_W   = 8;
    localparam int IN_POS_W = 16;
    localparam int SPAN_W   = 12;
    localparam int FLAG_W   = 16;
    localparam int COORD_W  = 12;
    localparam int COUNT_W  = 9;
    localparam int MASK_W   = 16;
    localparam int HIDX_W   = 8;

    // configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_ADDR_W-1:0] REG_ENTRY_COUNT    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ACTIVE_MASK    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_COLLISION_MASK = 2'd2;

    localparam logic [COUNT_W-1:0] ENTRY_COUNT_RST    = 9'd0;
    localparam logic [MASK_W-1:0]  ACTIVE_MASK_RST    = 16'd1;
    localparam logic [MASK_W-1:0]  COLLISION_MASK_RST = 16'd2;

    // item kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // parameter defaults
    localparam int DEF_MAX_ENTRIES = 256;
    localparam int DEF_TILE_SHIFT  = 4;
    localparam int DEF_POS_WIDTH   = 16;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic                kind;
        logic [SLOT_W-1:0]   entry_slot;
        logic [IN_POS_W-1:0] pos_x;
        logic [IN_POS_W-1:0] pos_y;
        logic [SPAN_W-1:0]   span_w;
        logic [SPAN_W-1:0]   span_h;
        logic                has_script;
        logic [FLAG_W-1:0]   entry_flags;
        logic [COORD_W-1:0]  query_x;
        logic [COORD_W-1:0]  query_y;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } push_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } head_t;

    typedef struct packed {
        logic [COUNT_W-1:0] entry_count;
        logic [MASK_W-1:0]  active_mask;
        logic [MASK_W-1:0]  collision_mask;
    } cfg_t;

endpackage

`default_nettype wire

@@ hdl/fmtrh_front.sv @@
// Front end: takes start transactions, drops writes to slots outside the table
// and hands the rest to the queue. Depends on fmtrh_pkg.
`default_nettype none

module fmtrh_front
    import fmtrh_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
)
(
    input  wire logic                start,
    input  wire logic                full,
    input  wire logic                kind,
    input  wire logic [SLOT_W-1:0]   entry_slot,
    input  wire logic [IN_POS_W-1:0] pos_x,
    input  wire logic [IN_POS_W-1:0] pos_y,
    input  wire logic [SPAN_W-1:0]   span_w,
    input  wire logic [SPAN_W-1:0]   span_h,
    input  wire logic                has_script,
    input  wire logic [FLAG_W-1:0]   entry_flags,
    input  wire logic [COORD_W-1:0]  query_x,
    input  wire logic [COORD_W-1:0]  query_y,
    output push_t                    push
);

    logic [31:0] slot_wide;
    logic        slot_ok;
    logic        keep;

    assign slot_wide = {{(32 - SLOT_W){1'b0}}, entry_slot};
    assign slot_ok   = (slot_wide < 32'(MAX_ENTRIES));

    // writes beyond the table vanish here
    always_comb
    begin
        unique case (kind)
            KIND_WRITE: keep = slot_ok;
            KIND_QUERY: keep = 1'b1;
            default:    keep = 1'b0;
        endcase
    end

    assign push.valid           = start && !full && keep;
    assign push.item.kind        = kind;
    assign push.item.entry_slot  = entry_slot;
    assign push.item.pos_x       = pos_x;
    assign push.item.pos_y       = pos_y;
    assign push.item.span_w      = span_w;
    assign push.item.span_h      = span_h;
    assign push.item.has_script  = has_script;
    assign push.item.entry_flags = entry_flags;
    assign push.item.query_x     = query_x;
    assign push.item.query_y     = query_y;

endmodule

`default_nettype wire

@@ hdl/fmtrh_queue.sv @@
// Short FIFO between the front end and the scan engine.
// Depends on fmtrh_pkg (item type and depth).
`default_nettype none

module fmtrh_queue
    import fmtrh_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  push_t     push,
    input  wire logic pop,
    output head_t     head,
    output logic      full
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    item_t            slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_pop;

    assign full       = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign head.valid = (cnt_reg != '0);
    assign head.item  = slot_reg[rd_ptr_reg];
    assign do_pop     = pop && head.valid;

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            slot_reg[wr_ptr_reg] <= push.item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push.valid)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push.valid && !do_pop)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (do_pop && !push.valid)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

@@ hdl/fmtrh_back.sv @@
// Back end: entry table memory and the first-match scan engine.
// Writes store one row; a query walks rows 1..count-1, one a cycle.
// Depends on fmtrh_pkg.
`default_nettype none

module fmtrh_back
    import fmtrh_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int TILE_SHIFT  = DEF_TILE_SHIFT,
    parameter int POS_WIDTH   = DEF_POS_WIDTH
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  cfg_t                  cfg,
    input  head_t                 head,
    output logic                  pop,
    output logic                  done,
    output logic                  hit,
    output logic [HIDX_W-1:0]     hit_index,
    output logic                  collides
);

    localparam int IDX_W  = $clog2(MAX_ENTRIES);
    localparam int CMAX_W = $clog2(MAX_ENTRIES + 1);
    localparam int LIM_W  = (CMAX_W > COUNT_W) ? CMAX_W : COUNT_W;
    localparam int SUM_W  = ((POS_WIDTH > SPAN_W) ? POS_WIDTH : SPAN_W) + 1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    typedef struct packed {
        logic [POS_WIDTH-1:0] pos_x;
        logic [POS_WIDTH-1:0] pos_y;
        logic [SPAN_W-1:0]    span_w;
        logic [SPAN_W-1:0]    span_h;
        logic                 script;
        logic [FLAG_W-1:0]    flags;
    } entry_t;

    entry_t entry_mem_reg [MAX_ENTRIES];
    entry_t rd_data_reg;
    entry_t wr_entry;

    logic                 state_reg, state_next;
    logic [LIM_W-1:0]     limit_reg, limit_next;
    logic [LIM_W-1:0]     issue_reg, issue_next;
    logic [LIM_W-1:0]     chk_idx_reg, chk_idx_next;
    logic                 chk_valid_reg, chk_valid_next;
    logic                 chk_last_reg, chk_last_next;
    logic [COORD_W-1:0]   qx_reg, qx_next;
    logic [COORD_W-1:0]   qy_reg, qy_next;
    logic                 done_reg, done_next;
    logic                 hit_reg, hit_next;
    logic [HIDX_W-1:0]    hidx_reg, hidx_next;
    logic                 coll_reg, coll_next;

    logic                 mem_we;
    logic [31:0]          slot_wide;
    logic [31:0]          px_wide;
    logic [31:0]          py_wide;
    logic [IDX_W-1:0]     wr_addr;
    logic [IDX_W-1:0]     rd_addr;
    logic [LIM_W-1:0]     count_ext;
    logic [LIM_W-1:0]     limit_c;
    logic [LIM_W-1:0]     issue_inc;

    logic [POS_WIDTH-1:0] tx;
    logic [POS_WIDTH-1:0] ty;
    logic [SUM_W-1:0]     tx_e, ty_e, sw_e, sh_e, qx_e, qy_e;
    logic                 in_x, in_y, enabled, match, coll_c;

    // write path
    assign slot_wide       = {{(32 - SLOT_W){1'b0}}, head.item.entry_slot};
    assign px_wide         = {{(32 - IN_POS_W){1'b0}}, head.item.pos_x};
    assign py_wide         = {{(32 - IN_POS_W){1'b0}}, head.item.pos_y};
    assign wr_addr         = slot_wide[IDX_W-1:0];
    assign wr_entry.pos_x  = px_wide[POS_WIDTH-1:0];
    assign wr_entry.pos_y  = py_wide[POS_WIDTH-1:0];
    assign wr_entry.span_w = head.item.span_w;
    assign wr_entry.span_h = head.item.span_h;
    assign wr_entry.script = head.item.has_script;
    assign wr_entry.flags  = head.item.entry_flags;

    assign rd_addr = issue_reg[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem_reg[wr_addr] <= wr_entry;
        end
        rd_data_reg <= entry_mem_reg[rd_addr];
    end

    // scan bound, clamped to the table size
    assign count_ext = LIM_W'(cfg.entry_count);
    assign limit_c   = (count_ext > LIM_W'(MAX_ENTRIES)) ? LIM_W'(MAX_ENTRIES) : count_ext;
    assign issue_inc = issue_reg + LIM_W'(1);

    // hit test on the row read last cycle; tile rectangle is half open
    assign tx      = rd_data_reg.pos_x >> TILE_SHIFT;
    assign ty      = rd_data_reg.pos_y >> TILE_SHIFT;
    assign tx_e    = SUM_W'(tx);
    assign ty_e    = SUM_W'(ty);
    assign sw_e    = SUM_W'(rd_data_reg.span_w);
    assign sh_e    = SUM_W'(rd_data_reg.span_h);
    assign qx_e    = SUM_W'(qx_reg);
    assign qy_e    = SUM_W'(qy_reg);
    assign in_x    = (tx_e <= qx_e) && (qx_e < tx_e + sw_e);
    assign in_y    = (ty_e <= qy_e) && (qy_e < ty_e + sh_e);
    assign enabled = rd_data_reg.script && ((rd_data_reg.flags & cfg.active_mask) != '0);
    assign match   = enabled && in_x && in_y;
    assign coll_c  = ((rd_data_reg.flags & cfg.collision_mask) != '0);

    always_comb
    begin
        state_next     = state_reg;
        limit_next     = limit_reg;
        issue_next     = issue_reg;
        chk_idx_next   = chk_idx_reg;
        chk_valid_next = 1'b0;
        chk_last_next  = chk_last_reg;
        qx_next        = qx_reg;
        qy_next        = qy_reg;
        done_next      = 1'b0;
        hit_next       = hit_reg;
        hidx_next      = hidx_reg;
        coll_next      = coll_reg;
        pop            = 1'b0;
        mem_we         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    if (head.item.kind == KIND_WRITE)
                    begin
                        mem_we = 1'b1;
                    end
                    else
                    begin
                        qx_next    = head.item.query_x;
                        qy_next    = head.item.query_y;
                        limit_next = limit_c;
                        if (limit_c <= LIM_W'(1))
                        begin
                            done_next = 1'b1;
                            hit_next  = 1'b0;
                            hidx_next = '0;
                            coll_next = 1'b0;
                        end
                        else
                        begin
                            issue_next = LIM_W'(1);
                            state_next = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                if (issue_reg < limit_reg)
                begin
                    chk_valid_next = 1'b1;
                    chk_idx_next   = issue_reg;
                    chk_last_next  = (issue_inc == limit_reg);
                    issue_next     = issue_inc;
                end
                if (chk_valid_reg && (match || chk_last_reg))
                begin
                    // first match or the last row ends the scan; the read already in flight is dropped
                    chk_valid_next = 1'b0;
                    state_next     = ST_IDLE;
                    done_next      = 1'b1;
                    hit_next       = match;
                    hidx_next      = match ? chk_idx_reg[HIDX_W-1:0] : '0;
                    coll_next      = match && coll_c;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            chk_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chk_valid_reg <= chk_valid_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        limit_reg    <= limit_next;
        issue_reg    <= issue_next;
        chk_idx_reg  <= chk_idx_next;
        chk_last_reg <= chk_last_next;
        qx_reg       <= qx_next;
        qy_reg       <= qy_next;
        hit_reg      <= hit_next;
        hidx_reg     <= hidx_next;
        coll_reg     <= coll_next;
    end

    assign done      = done_reg;
    assign hit       = hit_reg;
    assign hit_index = hidx_reg;
    assign collides  = coll_reg;

endmodule

`default_nettype wire

@@ hdl/first_match_tile_rect_hit_test_unit.sv @@
// Top level of the tile rectangle hit test unit: configuration registers,
// front end, queue and scan engine. Depends on fmtrh_pkg and the fmtrh_* modules.
//
// Usage:
//   A transaction is taken on a rising edge with start high and busy low.
//   kind selects a table write (entry_slot and entry fields) or a tile query
//   (query_x, query_y). Accepted transactions wait in a two-deep queue, so the
//   front keeps taking work while the scan engine is occupied; busy is high
//   only while that queue is full.
//   A write is stored as the engine pops it from the queue and gives no result.
//   A query gives one result on hit, hit_index and collides, marked by done
//   for a single cycle. The engine reads rows from 1 up and tests each row it
//   has read, ending at the first match or the last row; a count of one or
//   less reports a miss without a read. The table has one read port, so rows
//   are scanned one after another and no new item is popped during a scan.
//   The receiver cannot stall; done is never held.
//   Configuration (cfg_we, cfg_addr, cfg_wdata) is written with no wait and
//   must only change while the unit is idle. Reset clears the queue, the
//   engine and the registers; table contents stay undefined until written.
`default_nettype none

module first_match_tile_rect_hit_test_unit
    import fmtrh_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int TILE_SHIFT  = DEF_TILE_SHIFT,
    parameter int POS_WIDTH   = DEF_POS_WIDTH
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  kind,
    input  wire logic [SLOT_W-1:0]     entry_slot,
    input  wire logic [IN_POS_W-1:0]   pos_x,
    input  wire logic [IN_POS_W-1:0]   pos_y,
    input  wire logic [SPAN_W-1:0]     span_w,
    input  wire logic [SPAN_W-1:0]     span_h,
    input  wire logic                  has_script,
    input  wire logic [FLAG_W-1:0]     entry_flags,
    input  wire logic [COORD_W-1:0]    query_x,
    input  wire logic [COORD_W-1:0]    query_y,
    output logic                       done,
    output logic                       hit,
    output logic [HIDX_W-1:0]          hit_index,
    output logic                       collides
);

    logic [COUNT_W-1:0] entry_count_reg;
    logic [MASK_W-1:0]  active_mask_reg;
    logic [MASK_W-1:0]  collision_mask_reg;
    cfg_t               cfg;
    push_t              push;
    head_t              head;
    logic               pop;
    logic               full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg    <= ENTRY_COUNT_RST;
            active_mask_reg    <= ACTIVE_MASK_RST;
            collision_mask_reg <= COLLISION_MASK_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_ENTRY_COUNT:    entry_count_reg    <= cfg_wdata[COUNT_W-1:0];
                REG_ACTIVE_MASK:    active_mask_reg    <= cfg_wdata[MASK_W-1:0];
                REG_COLLISION_MASK: collision_mask_reg <= cfg_wdata[MASK_W-1:0];
                default:            ;
            endcase
        end
    end

    assign cfg.entry_count    = entry_count_reg;
    assign cfg.active_mask    = active_mask_reg;
    assign cfg.collision_mask = collision_mask_reg;

    assign busy = full;

    fmtrh_front #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_front (
        .start       (start),
        .full        (full),
        .kind        (kind),
        .entry_slot  (entry_slot),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .span_w      (span_w),
        .span_h      (span_h),
        .has_script  (has_script),
        .entry_flags (entry_flags),
        .query_x     (query_x),
        .query_y     (query_y),
        .push        (push)
    );

    fmtrh_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .full  (full)
    );

    fmtrh_back #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .TILE_SHIFT  (TILE_SHIFT),
        .POS_WIDTH   (POS_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .head      (head),
        .pop       (pop),
        .done      (done),
        .hit       (hit),
        .hit_index (hit_index),
        .collides  (collides)
    );

endmodule

`default_nettype wire

@@ verif/first_match_tile_rect_hit_test_unit_test.sv @@
// Self-checking bench for first_match_tile_rect_hit_test_unit: table writes and
// tile queries, predicted by an in-bench first-match scan and compared per field.
// Depends on fmtrh_pkg and the RTL under hdl/.
`timescale 1ns / 1ps

module first_match_tile_rect_hit_test_unit_test;
    import fmtrh_pkg::*;

    localparam int TABLE_DEPTH  = DEF_MAX_ENTRIES;
    localparam int TILE_SH      = DEF_TILE_SHIFT;
    localparam int ITEM_TARGET  = 1400;
    localparam int IDLE_GUARD   = 16;
    localparam int DRAIN_CYCLES = 300;
    localparam int COORD_TOP    = (1 << COORD_W) - 1;

    // index past the register list, must be ignored
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 2'd3;

    typedef struct {
        logic              hit;
        logic [HIDX_W-1:0] row;
        logic              col;
    } tile_answer_t;

    typedef enum {STEP_ITEM, STEP_REG} step_kind_t;

    typedef struct {
        step_kind_t            what;
        logic [CFG_ADDR_W-1:0] addr;
        logic [CFG_DATA_W-1:0] data;
        item_t                 it;
        bit                    typed;
        tile_answer_t          ans;
    } step_t;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata   = '0;
    logic                  start       = 1'b0;
    logic                  kind        = 1'b0;
    logic [SLOT_W-1:0]     entry_slot  = '0;
    logic [IN_POS_W-1:0]   pos_x       = '0;
    logic [IN_POS_W-1:0]   pos_y       = '0;
    logic [SPAN_W-1:0]     span_w      = '0;
    logic [SPAN_W-1:0]     span_h      = '0;
    logic                  has_script  = 1'b0;
    logic [FLAG_W-1:0]     entry_flags = '0;
    logic [COORD_W-1:0]    query_x     = '0;
    logic [COORD_W-1:0]    query_y     = '0;
    logic                  busy;
    logic                  done;
    logic                  hit;
    logic [HIDX_W-1:0]     hit_index;
    logic                  collides;

    // predictor copy of the table and registers
    logic [IN_POS_W-1:0] ent_px     [TABLE_DEPTH];
    logic [IN_POS_W-1:0] ent_py     [TABLE_DEPTH];
    logic [SPAN_W-1:0]   ent_w      [TABLE_DEPTH];
    logic [SPAN_W-1:0]   ent_h      [TABLE_DEPTH];
    logic                ent_script [TABLE_DEPTH];
    logic [FLAG_W-1:0]   ent_flags  [TABLE_DEPTH];
    logic [COUNT_W-1:0]  reg_count   = ENTRY_COUNT_RST;
    logic [MASK_W-1:0]   reg_active  = ACTIVE_MASK_RST;
    logic [MASK_W-1:0]   reg_collide = COLLISION_MASK_RST;

    tile_answer_t answers_due [$];
    step_t        dir_steps [$];

    int burst_left   = 0;
    int err_count    = 0;
    int items_sent   = 0;
    int queries_sent = 0;
    int results_seen = 0;
    int hits_seen    = 0;
    int settings     = 0;

    first_match_tile_rect_hit_test_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .entry_slot  (entry_slot),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .span_w      (span_w),
        .span_h      (span_h),
        .has_script  (has_script),
        .entry_flags (entry_flags),
        .query_x     (query_x),
        .query_y     (query_y),
        .done        (done),
        .hit         (hit),
        .hit_index   (hit_index),
        .collides    (collides)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic tile_answer_t answer(input logic h, input logic [HIDX_W-1:0] r,
                                            input logic c);
        tile_answer_t a;
        a.hit = h;
        a.row = r;
        a.col = c;
        return a;
    endfunction

    // first scriptful, active entry in 1..count-1 whose half-open tile rectangle covers the tile
    function automatic tile_answer_t first_cover(input logic [COORD_W-1:0] qx,
                                                 input logic [COORD_W-1:0] qy);
        tile_answer_t a;
        int lim;
        int tx;
        int ty;
        a = answer(1'b0, '0, 1'b0);
        lim = int'(reg_count);
        if (lim > TABLE_DEPTH)
            lim = TABLE_DEPTH;
        for (int i = 1; i < lim; i++)
        begin
            if (ent_script[i] === 1'b1 && (ent_flags[i] & reg_active) != '0)
            begin
                tx = int'(ent_px[i] >> TILE_SH);
                ty = int'(ent_py[i] >> TILE_SH);
                if (tx <= int'(qx) && tx + int'(ent_w[i]) > int'(qx) &&
                    ty <= int'(qy) && ty + int'(ent_h[i]) > int'(qy))
                begin
                    a.hit = 1'b1;
                    a.row = HIDX_W'(i);
                    a.col = (ent_flags[i] & reg_collide) != '0;
                    break;
                end
            end
        end
        return a;
    endfunction

    function automatic void store_entry(input item_t it);
        ent_px[it.entry_slot]     = it.pos_x;
        ent_py[it.entry_slot]     = it.pos_y;
        ent_w[it.entry_slot]      = it.span_w;
        ent_h[it.entry_slot]      = it.span_h;
        ent_script[it.entry_slot] = it.has_script;
        ent_flags[it.entry_slot]  = it.entry_flags;
    endfunction

    // unused fields carry noise
    function automatic item_t rand_item();
        item_t it;
        it.kind        = 1'($urandom);
        it.entry_slot  = SLOT_W'($urandom);
        it.pos_x       = IN_POS_W'($urandom);
        it.pos_y       = IN_POS_W'($urandom);
        it.span_w      = SPAN_W'($urandom);
        it.span_h      = SPAN_W'($urandom);
        it.has_script  = 1'($urandom);
        it.entry_flags = FLAG_W'($urandom);
        it.query_x     = COORD_W'($urandom);
        it.query_y     = COORD_W'($urandom);
        return it;
    endfunction

    function automatic item_t make_write(input logic [SLOT_W-1:0] slot,
                                         input logic [IN_POS_W-1:0] px,
                                         input logic [IN_POS_W-1:0] py,
                                         input logic [SPAN_W-1:0] w,
                                         input logic [SPAN_W-1:0] h,
                                         input logic scr,
                                         input logic [FLAG_W-1:0] flg);
        item_t it;
        it = rand_item();
        it.kind        = KIND_WRITE;
        it.entry_slot  = slot;
        it.pos_x       = px;
        it.pos_y       = py;
        it.span_w      = w;
        it.span_h      = h;
        it.has_script  = scr;
        it.entry_flags = flg;
        return it;
    endfunction

    function automatic item_t make_query(input logic [COORD_W-1:0] qx,
                                         input logic [COORD_W-1:0] qy);
        item_t it;
        it = rand_item();
        it.kind    = KIND_QUERY;
        it.query_x = qx;
        it.query_y = qy;
        return it;
    endfunction

    function automatic void dir_item(input item_t it, input bit typed,
                                     input tile_answer_t ans);
        step_t s;
        s.what  = STEP_ITEM;
        s.addr  = '0;
        s.data  = '0;
        s.it    = it;
        s.typed = typed;
        s.ans   = ans;
        dir_steps.push_back(s);
    endfunction

    function automatic void dir_reg(input logic [CFG_ADDR_W-1:0] addr,
                                    input logic [CFG_DATA_W-1:0] data);
        step_t s;
        s.what  = STEP_REG;
        s.addr  = addr;
        s.data  = data;
        s.it    = rand_item();
        s.typed = 1'b0;
        s.ans   = answer(1'b0, '0, 1'b0);
        dir_steps.push_back(s);
    endfunction

    function automatic logic [SPAN_W-1:0] rand_span();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r <= 5)
            return SPAN_W'($urandom_range(1, 16));
        if (r <= 8)
            return SPAN_W'($urandom);
        return '1;
    endfunction

    function automatic logic [MASK_W-1:0] rand_mask();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        if (r <= 3)
            return MASK_W'(1 << $urandom_range(0, MASK_W - 1));
        return MASK_W'($urandom);
    endfunction

    // coordinate on or just off an edge of a rectangle, or inside it
    function automatic logic [COORD_W-1:0] near_edge(input int lo, input int span);
        int v;
        case ($urandom_range(0, 4))
            0: v = lo;
            1: v = lo - 1;
            2: v = lo + span - 1;
            3: v = lo + span;
            default: v = lo + int'($urandom_range(0, span));
        endcase
        if (v < 0)
            v = 0;
        if (v > COORD_TOP)
            v = COORD_TOP;
        return COORD_W'(v);
    endfunction

    task automatic report_mismatch(input string what);
        err_count++;
        $display("MISMATCH @%0t: %s", $time, what);
    endtask

    // sender works in bursts; start only drops at a gap
    task automatic issue(input item_t it, input bit typed, input tile_answer_t ans);
        if (burst_left == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 30);
        end
        start       <= 1'b1;
        kind        <= it.kind;
        entry_slot  <= it.entry_slot;
        pos_x       <= it.pos_x;
        pos_y       <= it.pos_y;
        span_w      <= it.span_w;
        span_h      <= it.span_h;
        has_script  <= it.has_script;
        entry_flags <= it.entry_flags;
        query_x     <= it.query_x;
        query_y     <= it.query_y;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        burst_left--;
        items_sent++;
        if (it.kind == KIND_WRITE)
            store_entry(it);
        else
        begin
            answers_due.push_back(typed ? ans : first_cover(it.query_x, it.query_y));
            queries_sent++;
        end
    endtask

    // all queries answered, then room for queued writes to drain
    task automatic settle();
        start <= 1'b0;
        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (IDLE_GUARD) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge clk);
        case (addr)
            REG_ENTRY_COUNT:    reg_count   = data[COUNT_W-1:0];
            REG_ACTIVE_MASK:    reg_active  = data[MASK_W-1:0];
            REG_COLLISION_MASK: reg_collide = data[MASK_W-1:0];
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        tile_answer_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            results_seen++;
            if (hit === 1'b1)
                hits_seen++;
            if (answers_due.size() == 0)
                report_mismatch($sformatf("result with no query outstanding: hit=%b row=%0d",
                                          hit, hit_index));
            else
            begin
                want = answers_due.pop_front();
                if (hit !== want.hit)
                    report_mismatch($sformatf("hit %b, wanted %b", hit, want.hit));
                if (hit_index !== want.row)
                    report_mismatch($sformatf("hit_index %0d, wanted %0d",
                                              hit_index, want.row));
                if (collides !== want.col)
                    report_mismatch($sformatf("collides %b, wanted %b", collides, want.col));
            end
        end
    end

    initial
    begin
        tile_answer_t none;
        logic [CFG_DATA_W-1:0] data;
        logic [COORD_W-1:0] qx;
        logic [COORD_W-1:0] qy;
        logic [SLOT_W-1:0] slot;
        int n_items;
        int lim;
        int k;

        none = answer(1'b0, '0, 1'b0);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every slot written once, without script, so no scan meets an unwritten entry
        for (int s = 0; s < TABLE_DEPTH; s++)
            issue(make_write(SLOT_W'(s), IN_POS_W'($urandom), IN_POS_W'($urandom),
                             SPAN_W'($urandom), SPAN_W'($urandom), 1'b0,
                             FLAG_W'($urandom)), 1'b0, none);

        // registers still at reset: count 0 scans nothing
        dir_item(make_query(12'd0, 12'd0), 1'b1, none);
        dir_reg(REG_ENTRY_COUNT, 16'd1);
        dir_item(make_query(12'hFFF, 12'hFFF), 1'b1, none);
        // slot 0 is stored but never scanned
        dir_item(make_write(8'd0, 16'h0000, 16'h0000, 12'hFFF, 12'hFFF, 1'b1, 16'hFFFF),
                 1'b0, none);
        dir_reg(REG_ENTRY_COUNT, 16'd2);
        dir_item(make_query(12'd0, 12'd0), 1'b1, none);
        // tiles x 1..3, y 2..3
        dir_item(make_write(8'd1, 16'h0010, 16'h0020, 12'd3, 12'd2, 1'b1, 16'h0003),
                 1'b0, none);
        dir_item(make_query(12'd1, 12'd2), 1'b1, answer(1'b1, 8'd1, 1'b1));
        dir_item(make_query(12'd3, 12'd3), 1'b1, answer(1'b1, 8'd1, 1'b1));
        dir_item(make_query(12'd4, 12'd2), 1'b1, none);
        dir_item(make_query(12'd1, 12'd4), 1'b1, none);
        dir_item(make_query(12'd0, 12'd2), 1'b1, none);
        // far corner, end sum past 12 bits
        dir_item(make_write(8'd2, 16'hFFFF, 16'hFFFF, 12'hFFF, 12'hFFF, 1'b1, 16'h0001),
                 1'b0, none);
        dir_reg(REG_ENTRY_COUNT, 16'd3);
        dir_item(make_query(12'hFFF, 12'hFFF), 1'b1, answer(1'b1, 8'd2, 1'b0));
        // covers everything but has no script
        dir_item(make_write(8'd1, 16'h0000, 16'h0000, 12'hFFF, 12'hFFF, 1'b0, 16'hFFFF),
                 1'b0, none);
        dir_item(make_query(12'hFFF, 12'hFFF), 1'b1, answer(1'b1, 8'd2, 1'b0));
        dir_item(make_query(12'd10, 12'd10), 1'b1, none);
        dir_reg(REG_ACTIVE_MASK, 16'h0000);
        dir_item(make_query(12'hFFF, 12'hFFF), 1'b1, none);
        dir_reg(REG_ACTIVE_MASK, 16'hFFFF);
        dir_reg(REG_COLLISION_MASK, 16'hFFFF);
        dir_item(make_query(12'hFFF, 12'hFFF), 1'b1, answer(1'b1, 8'd2, 1'b1));
        // zero extent never covers
        dir_item(make_write(8'd1, 16'h0005, 16'h0000, 12'd0, 12'd0, 1'b1, 16'hFFFF),
                 1'b0, none);
        dir_item(make_query(12'd0, 12'd0), 1'b1, none);
        dir_item(make_write(8'd3, 16'h0000, 16'h0000, 12'hFFF, 12'hFFF, 1'b1, 16'h8000),
                 1'b0, none);
        // count above the table is clamped
        dir_reg(REG_ENTRY_COUNT, 16'h01FF);
        dir_reg(REG_COLLISION_MASK, 16'h0000);
        dir_item(make_query(12'd100, 12'd100), 1'b1, answer(1'b1, 8'd3, 1'b0));
        dir_reg(REG_SPARE, 16'hFFFF);
        dir_item(make_write(8'd255, 16'h0000, 16'hFFF0, 12'd1, 12'd1, 1'b1, 16'h0001),
                 1'b0, none);
        dir_item(make_query(12'hFFF, 12'd0), 1'b0, none);
        dir_reg(REG_ENTRY_COUNT, 16'hFF00);
        dir_item(make_query(12'd0, 12'hFFF), 1'b0, none);

        foreach (dir_steps[i])
        begin
            if (dir_steps[i].what == STEP_REG)
            begin
                settle();
                write_reg(dir_steps[i].addr, dir_steps[i].data);
                settings++;
            end
            else
                issue(dir_steps[i].it, dir_steps[i].typed, dir_steps[i].ans);
        end

        // random phases: new register setting, then a burst of writes and queries
        while (items_sent < ITEM_TARGET)
        begin
            settle();
            settings++;
            case ($urandom_range(0, 9))
                0: lim = $urandom_range(0, 1);
                1: lim = $urandom_range(255, 256);
                2: lim = $urandom_range(257, 511);
                default: lim = $urandom_range(2, 24);
            endcase
            data = CFG_DATA_W'($urandom);
            data[COUNT_W-1:0] = COUNT_W'(lim);
            write_reg(REG_ENTRY_COUNT, data);
            write_reg(REG_ACTIVE_MASK, rand_mask());
            write_reg(REG_COLLISION_MASK, rand_mask());
            if ($urandom_range(0, 7) == 0)
                write_reg(REG_SPARE, CFG_DATA_W'($urandom));
            if (lim > TABLE_DEPTH)
                lim = TABLE_DEPTH;

            n_items = $urandom_range(8, 40);
            for (int j = 0; j < n_items; j++)
            begin
                if ($urandom_range(0, 99) < 35)
                begin
                    if (lim > 1 && $urandom_range(0, 3) != 0)
                        slot = SLOT_W'($urandom_range(1, lim - 1));
                    else
                        slot = SLOT_W'($urandom);
                    issue(make_write(slot, IN_POS_W'($urandom), IN_POS_W'($urandom),
                                     rand_span(), rand_span(), $urandom_range(0, 6) != 0,
                                     rand_mask()), 1'b0, none);
                end
                else
                begin
                    if (lim > 1 && $urandom_range(0, 99) < 65)
                    begin
                        k  = $urandom_range(1, lim - 1);
                        qx = near_edge(int'(ent_px[k] >> TILE_SH), int'(ent_w[k]));
                        qy = near_edge(int'(ent_py[k] >> TILE_SH), int'(ent_h[k]));
                    end
                    else
                    begin
                        qx = COORD_W'($urandom);
                        qy = COORD_W'($urandom);
                    end
                    issue(make_query(qx, qy), 1'b0, none);
                end
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d transactions: %0d queries, %0d results, %0d hits,",
                 items_sent, queries_sent, results_seen, hits_seen);
        $display("across %0d register settings; %0d mismatches.", settings, err_count);
        if (err_count == 0 && answers_due.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Timed out with %0d queries unanswered", answers_due.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
